// File: hdl/tape_language_interpreter_core_top_defines.svh
// Assertion macros shared by the interpreter core RTL.
`ifndef TAPE_LANGUAGE_INTERPRETER_CORE_TOP_DEFINES_SVH
`define TAPE_LANGUAGE_INTERPRETER_CORE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tli_pkg.sv
// Types, sizes and command codes of the tape language interpreter core.
package tli_pkg;

	localparam int PROG_DEPTH = 4096;
	localparam int TAPE_DEPTH = 32768;
	localparam int LOOP_DEPTH = 64;

	localparam int PA_W = $clog2(PROG_DEPTH);
	localparam int IP_W = PA_W + 1;
	localparam int DP_W = $clog2(TAPE_DEPTH);
	localparam int SA_W = $clog2(LOOP_DEPTH);
	localparam int SC_W = SA_W + 1;
	localparam int ADDR_OUT_W = 13;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;

	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_OUT   = 3'd1,
		STAT_WAIT  = 3'd2,
		STAT_HALT  = 3'd3,
		STAT_FAULT = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] load_char;
		logic       load_last;
		logic [7:0] in_byte;
		logic       in_valid;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [7:0]            out_byte;
		logic [ADDR_OUT_W-1:0] instr_addr;
	} res_t;

endpackage

// File: hdl/tli_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tli_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/tape_language_interpreter_core_top.sv
// Top level of the tape language interpreter core: sequencer, state registers, memories.
//
//  channel | valid     | stall     | payload | direction
//  --------+-----------+-----------+---------+----------
//  request | req_valid | req_stall | req     | in
//  result  | res_valid | res_stall | res     | out
//
// Every request goes through an accept cycle, which reads program, tape and loop stack
// memories, and an execute cycle, which writes them back and loads the result register.
// After reset a clear pass zeroes all 32768 tape cells, one cell per cycle; req_stall
// stays high meanwhile.
// A result held by res_stall keeps the core in its execute cycle until the slot frees.
`include "tape_language_interpreter_core_top_defines.svh"

module tape_language_interpreter_core_top import tli_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	fsm_t state_q, state_nxt;

	req_t req_q;
	logic [IP_W-1:0] len_q, len_nxt;
	logic [IP_W-1:0] ip_q, ip_nxt;
	logic [DP_W-1:0] dp_q, dp_nxt;
	logic [SC_W-1:0] sc_q, sc_nxt;
	logic [IP_W-1:0] skip_q, skip_nxt;
	logic            fault_q, fault_nxt;
	logic [DP_W-1:0] clr_addr_q;

	logic res_valid_q;
	res_t res_q;

	logic    accept, exec_done, clearing;
	status_t stat;
	logic [7:0] ob;

	logic          prog_we_x, prog_we;
	logic [7:0]    prog_rdata;
	logic          tape_we_x, tape_we;
	logic [7:0]    tape_wd_x, tape_wdata, tape_rdata;
	logic [DP_W-1:0] tape_waddr;
	logic          stk_we_x, stk_we;
	logic [PA_W-1:0] stk_rdata;
	logic [SA_W-1:0] stk_raddr;

	// memories
	assign stk_raddr = SA_W'(sc_q - SC_W'(1));

	tli_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog (
		.clk   (clk),
		.we    (prog_we),
		.waddr (len_q[PA_W-1:0]),
		.wdata (req_q.load_char),
		.re    (accept),
		.raddr (ip_q[PA_W-1:0]),
		.rdata (prog_rdata)
	);

	tli_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (accept),
		.raddr (dp_q),
		.rdata (tape_rdata)
	);

	tli_ram #(.DEPTH(LOOP_DEPTH), .WIDTH(PA_W)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sc_q[SA_W-1:0]),
		.wdata (ip_q[PA_W-1:0]),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (clr_addr_q == DP_W'(TAPE_DEPTH - 1)) begin
					state_nxt = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (accept) begin
					state_nxt = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (exec_done) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		clearing   = (state_q == FSM_CLEAR);
		req_stall  = (state_q != FSM_IDLE);
		accept     = req_valid && !req_stall;
		exec_done  = (state_q == FSM_EXEC) && (!res_valid_q || !res_stall);
		prog_we    = exec_done && prog_we_x;
		stk_we     = exec_done && stk_we_x;
		tape_we    = clearing || (exec_done && tape_we_x);
		tape_waddr = clearing ? clr_addr_q : dp_q;
		tape_wdata = clearing ? 8'h00 : tape_wd_x;
	end

	// instruction execution on the read data
	always_comb begin
		len_nxt   = len_q;
		ip_nxt    = ip_q;
		dp_nxt    = dp_q;
		sc_nxt    = sc_q;
		skip_nxt  = skip_q;
		fault_nxt = fault_q;
		stat      = STAT_OK;
		ob        = 8'h00;
		prog_we_x = 1'b0;
		tape_we_x = 1'b0;
		tape_wd_x = tape_rdata;
		stk_we_x  = 1'b0;
		if (fault_q) begin
			stat = STAT_FAULT;
		end else if (req_q.req_type == REQ_LOAD) begin
			if (len_q >= IP_W'(PROG_DEPTH)) begin
				fault_nxt = 1'b1;
				stat      = STAT_FAULT;
			end else begin
				prog_we_x = 1'b1;
				len_nxt   = len_q + IP_W'(1);
				if (req_q.load_last) begin
					ip_nxt   = '0;
					sc_nxt   = '0;
					skip_nxt = '0;
				end
			end
		end else if (ip_q >= len_q) begin
			stat = STAT_HALT;
		end else if (skip_q != '0) begin
			if (prog_rdata == CH_OPEN) begin
				skip_nxt = skip_q + IP_W'(1);
			end else if (prog_rdata == CH_CLOSE) begin
				skip_nxt = skip_q - IP_W'(1);
			end
			ip_nxt = ip_q + IP_W'(1);
		end else begin
			ip_nxt = ip_q + IP_W'(1);
			case (prog_rdata)
				CH_INC: begin
					tape_we_x = 1'b1;
					tape_wd_x = tape_rdata + 8'd1;
				end
				CH_DEC: begin
					tape_we_x = 1'b1;
					tape_wd_x = tape_rdata - 8'd1;
				end
				CH_RIGHT: begin
					dp_nxt = (dp_q == DP_W'(TAPE_DEPTH - 1)) ? '0 : dp_q + DP_W'(1);
				end
				CH_LEFT: begin
					dp_nxt = (dp_q == '0) ? DP_W'(TAPE_DEPTH - 1) : dp_q - DP_W'(1);
				end
				CH_OPEN: begin
					if (tape_rdata == 8'h00) begin
						skip_nxt = IP_W'(1);
					end else if (sc_q >= SC_W'(LOOP_DEPTH)) begin
						fault_nxt = 1'b1;
						stat      = STAT_FAULT;
						ip_nxt    = ip_q;
					end else begin
						stk_we_x = 1'b1;
						sc_nxt   = sc_q + SC_W'(1);
					end
				end
				CH_CLOSE: begin
					if (sc_q == '0) begin
						fault_nxt = 1'b1;
						stat      = STAT_FAULT;
						ip_nxt    = ip_q;
					end else if (tape_rdata == 8'h00) begin
						sc_nxt = sc_q - SC_W'(1);
					end else begin
						ip_nxt = IP_W'(stk_rdata) + IP_W'(1);
					end
				end
				CH_OUT: begin
					stat = STAT_OUT;
					ob   = tape_rdata;
				end
				CH_IN: begin
					if (!req_q.in_valid) begin
						stat   = STAT_WAIT;
						ip_nxt = ip_q;
					end else begin
						tape_we_x = 1'b1;
						tape_wd_x = req_q.in_byte;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			clr_addr_q  <= '0;
			len_q       <= '0;
			ip_q        <= '0;
			dp_q        <= '0;
			sc_q        <= '0;
			skip_q      <= '0;
			fault_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (clearing) begin
				clr_addr_q <= clr_addr_q + DP_W'(1);
			end
			if (exec_done) begin
				len_q       <= len_nxt;
				ip_q        <= ip_nxt;
				dp_q        <= dp_nxt;
				sc_q        <= sc_nxt;
				skip_q      <= skip_nxt;
				fault_q     <= fault_nxt;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (exec_done) begin
			res_q.status     <= stat;
			res_q.out_byte   <= ob;
			res_q.instr_addr <= ADDR_OUT_W'(ip_nxt);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`TLI_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_q == FSM_EXEC, "accepted request not executed")
	`TLI_ASSERT_NEXT(a_fault_sticky, fault_q, fault_q, "fault flag dropped")
	`TLI_ASSERT_NEXT(a_fault_status, exec_done && fault_q, res_valid && res.status == STAT_FAULT, "fault not reported")
	`TLI_ASSERT_NOW(a_stack_bound, 1'b1, sc_q <= SC_W'(LOOP_DEPTH), "loop stack count out of range")
	`TLI_ASSERT_NOW(a_ip_bound, 1'b1, ip_q <= len_q, "instruction pointer past program end")

endmodule

// File: tb/sv/tape_language_interpreter_core_top_tb.sv
// Self-checking testbench for the tape language interpreter core.
module tape_language_interpreter_core_top_tb;
	import tli_pkg::*;

	localparam int ITEMS = 1600;

	typedef struct packed {
		logic       is_step;
		logic [7:0] ch;
		logic       last;
		logic [7:0] ib;
		logic       iv;
		logic       typed;
		res_t       want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int idle_pct = 10;
	int stall_pct = 63;
	int errors = 0;
	int n_items = 0;
	res_t expected_q[$];
	logic [7:0] frag_q[$];

	// interpreter state as predicted
	logic [7:0] prog_mem [PROG_DEPTH];
	logic [7:0] tape [TAPE_DEPTH];
	int loop_stk [LOOP_DEPTH];
	int prog_len = 0;
	int ip = 0;
	int dp = 0;
	int stk_cnt = 0;
	int skip_lvl = 0;
	bit faulted = 1'b0;

	dir_row_t dir_tab [24] = '{
		'{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b1, '{STAT_HALT, 8'h00, 13'd0}},
		'{1'b0, CH_IN, 1'b0, 8'h00, 1'b0, 1'b1, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'hFF, 1'b0, 1'b1, '{STAT_WAIT, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'hFF, 1'b1, 1'b1, '{STAT_OK, 8'h00, 13'd1}},
		'{1'b0, CH_OUT, 1'b0, 8'h00, 1'b0, 1'b1, '{STAT_OK, 8'h00, 13'd1}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, '{STAT_OUT, 8'hFF, 13'd2}},
		'{1'b0, CH_INC, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, CH_OPEN, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, CH_CLOSE, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, CH_IN, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, CH_OPEN, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, CH_IN, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b0, CH_CLOSE, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h01, 1'b1, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h02, 1'b1, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, '{STAT_OK, 8'h00, 13'd0}},
		'{1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, '{STAT_OK, 8'h00, 13'd0}}
	};

	tape_language_interpreter_core_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: %0d %02h %0d",
					$time, res.status, res.out_byte, res.instr_addr);
			end else begin
				want = expected_q.pop_front();
				if (res !== want) begin
					errors++;
					$display("%0t: expected %0d %02h %0d, got %0d %02h %0d",
						$time, want.status, want.out_byte, want.instr_addr,
						res.status, res.out_byte, res.instr_addr);
				end
			end
		end
	end

	function automatic res_t interp_step(req_t r);
		res_t o;
		status_t st;
		logic [7:0] ob;
		logic [7:0] c;
		bit adv;
		st = STAT_OK;
		ob = 8'h00;
		adv = 1'b0;
		if (faulted) begin
			st = STAT_FAULT;
		end else if (r.req_type == REQ_LOAD) begin
			if (prog_len >= PROG_DEPTH) begin
				faulted = 1'b1;
				st = STAT_FAULT;
			end else begin
				prog_mem[prog_len] = r.load_char;
				prog_len++;
				if (r.load_last) begin
					ip = 0;
					stk_cnt = 0;
					skip_lvl = 0;
				end
			end
		end else if (ip >= prog_len) begin
			st = STAT_HALT;
		end else begin
			c = prog_mem[ip];
			adv = 1'b1;
			if (skip_lvl > 0) begin
				if (c == CH_OPEN)
					skip_lvl++;
				else if (c == CH_CLOSE)
					skip_lvl--;
			end else begin
				case (c)
					CH_INC: tape[dp] = tape[dp] + 8'd1;
					CH_DEC: tape[dp] = tape[dp] - 8'd1;
					CH_RIGHT: dp = (dp + 1) % TAPE_DEPTH;
					CH_LEFT: dp = (dp + TAPE_DEPTH - 1) % TAPE_DEPTH;
					CH_OPEN: begin
						if (tape[dp] == 8'd0) begin
							skip_lvl = 1;
						end else if (stk_cnt >= LOOP_DEPTH) begin
							faulted = 1'b1;
							st = STAT_FAULT;
							adv = 1'b0;
						end else begin
							loop_stk[stk_cnt] = ip;
							stk_cnt++;
						end
					end
					CH_CLOSE: begin
						if (stk_cnt == 0) begin
							faulted = 1'b1;
							st = STAT_FAULT;
							adv = 1'b0;
						end else if (tape[dp] == 8'd0) begin
							stk_cnt--;
						end else begin
							ip = loop_stk[stk_cnt - 1] + 1;
							adv = 1'b0;
						end
					end
					CH_OUT: begin
						ob = tape[dp];
						st = STAT_OUT;
					end
					CH_IN: begin
						if (!r.in_valid) begin
							st = STAT_WAIT;
							adv = 1'b0;
						end else begin
							tape[dp] = r.in_byte;
						end
					end
					default: ;
				endcase
			end
			if (adv)
				ip++;
		end
		o.status = st;
		o.out_byte = ob;
		o.instr_addr = 13'(ip);
		return o;
	endfunction

	function automatic req_t load_req(logic [7:0] ch, logic last);
		req_t r;
		r.req_type = REQ_LOAD;
		r.load_char = ch;
		r.load_last = last;
		r.in_byte = 8'($urandom);
		r.in_valid = 1'($urandom);
		return r;
	endfunction

	// a count loaded right before '[' or at the program end stays small so loops stay short
	function automatic req_t step_req();
		req_t r;
		r.req_type = REQ_STEP;
		r.load_char = 8'($urandom);
		r.load_last = 1'($urandom);
		r.in_valid = ($urandom_range(0, 3) != 0);
		r.in_byte = 8'($urandom);
		if (!faulted && ip < prog_len && skip_lvl == 0 && prog_mem[ip] == CH_IN)
			if (ip + 1 >= prog_len || prog_mem[ip + 1] == CH_OPEN)
				r.in_byte = 8'($urandom_range(0, 3));
		return r;
	endfunction

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == CH_OPEN || c == CH_CLOSE);
		return c;
	endfunction

	function automatic void build_fragment();
		int n;
		n = $urandom_range(2, 6);
		frag_q.delete();
		repeat (n) begin
			if ($urandom_range(0, 9) < 3) begin
				frag_q = {frag_q, CH_IN, CH_OPEN};
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 5))
						0: frag_q = {frag_q, CH_RIGHT, CH_INC, CH_LEFT};
						1: frag_q = {frag_q, CH_RIGHT, CH_DEC, CH_LEFT};
						2: frag_q = {frag_q, CH_LEFT, CH_OUT, CH_RIGHT};
						3: frag_q.push_back(CH_OUT);
						4: frag_q.push_back(noise_char());
						default: frag_q = {frag_q, CH_RIGHT, CH_IN, CH_OPEN,
							CH_DEC, CH_CLOSE, CH_LEFT};
					endcase
				end
				frag_q = {frag_q, CH_DEC, CH_CLOSE};
			end else begin
				case ($urandom_range(0, 6))
					0: frag_q.push_back(CH_INC);
					1: frag_q.push_back(CH_DEC);
					2: frag_q.push_back(CH_RIGHT);
					3: frag_q.push_back(CH_LEFT);
					4: frag_q.push_back(CH_OUT);
					5: frag_q.push_back(CH_IN);
					default: frag_q.push_back(noise_char());
				endcase
			end
		end
	endfunction

	task automatic drive(input req_t r, input bit typed, input res_t typed_res);
		res_t want;
		want = interp_step(r);
		if (typed)
			want = typed_res;
		if ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_q.push_back(want);
	endtask

	task automatic run_steps(input int cap);
		int k;
		k = 0;
		while (!faulted && ip < prog_len && k < cap) begin
			drive(step_req(), 1'b0, '0);
			n_items++;
			k++;
		end
	endtask

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		req_t r;
		int kind;
		logic last;
		foreach (tape[i])
			tape[i] = 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			r.req_type = dir_tab[i].is_step ? REQ_STEP : REQ_LOAD;
			r.load_char = dir_tab[i].ch;
			r.load_last = dir_tab[i].last;
			r.in_byte = dir_tab[i].ib;
			r.in_valid = dir_tab[i].iv;
			drive(r, dir_tab[i].typed, dir_tab[i].want);
		end

		while (n_items < ITEMS) begin
			case (n_items * 3 / ITEMS)
				0: begin
					idle_pct = 10;
					stall_pct = 63;
				end
				1: begin
					idle_pct = 63;
					stall_pct = 10;
				end
				default: begin
					idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			build_fragment();
			foreach (frag_q[i]) begin
				if (i == frag_q.size() - 1)
					last = ($urandom_range(0, 15) == 0);
				else
					last = ($urandom_range(0, 63) == 0);
				drive(load_req(frag_q[i], last), 1'b0, '0);
				n_items++;
				if ($urandom_range(0, 3) == 0)
					run_steps($urandom_range(1, 3));
			end
			run_steps(120);
			if ($urandom_range(0, 3) == 0)
				drive(step_req(), 1'b0, '0);
		end

		// end the run on one kind of fault, then confirm it sticks
		run_steps(6000);
		kind = $urandom_range(0, 1);
		if (kind == 0 && ip >= prog_len && stk_cnt == 0 && skip_lvl == 0) begin
			drive(load_req(CH_CLOSE, 1'b0), 1'b0, '0);
			drive(step_req(), 1'b0, '0);
		end else if (kind == 1 && ip >= prog_len && skip_lvl == 0) begin
			if (tape[dp] == 8'h00)
				drive(load_req(CH_INC, 1'b0), 1'b0, '0);
			repeat (LOOP_DEPTH - stk_cnt + 1)
				drive(load_req(CH_OPEN, 1'b0), 1'b0, '0);
			run_steps(LOOP_DEPTH + 4);
		end
		while (!faulted)
			drive(load_req(noise_char(), 1'b0), 1'b0, '0);
		repeat (2) begin
			drive(load_req(8'($urandom), 1'($urandom)), 1'b0, '0);
			drive(step_req(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
